// ===== hw/rtl/bdec_pkg.sv =====
// ----------------------------------------------------------------------------
// bdec_pkg
// Shared types and constants for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bdec_pkg;

    localparam int MAX_LEN_W = 12;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 12'd2000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queue entry: up to two decoded candidate bytes from one input byte.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       last;
    } t_entry;

endpackage

// ===== hw/rtl/bdec_front.sv =====
// ----------------------------------------------------------------------------
// bdec_front
// Escape parser: takes template bytes, tracks escape state and numeric
// accumulation, and emits up to two candidate bytes per input byte.
// ----------------------------------------------------------------------------
module bdec_front import bdec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_template_end,
    input  logic       i_full,
    output logic       o_push,
    output t_entry     o_entry
);

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_FF     = 8'hFF;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX0  = 3'd2,
        PH_HEX1  = 3'd3,
        PH_OCT1  = 3'd4,
        PH_OCT2  = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [5:0] r_accum, n_accum;

    logic       accept;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       oct_ok;
    logic       do_plain;
    t_entry     ent;

    function automatic t_entry add_byte(t_entry e, logic [7:0] v);
        t_entry r;
        r = e;
        if (e.cnt == 2'd0) begin
            r.b0 = v;
        end else begin
            r.b1 = v;
        end
        r.cnt = e.cnt + 2'd1;
        return r;
    endfunction

    assign accept  = i_valid && !o_stall;
    assign o_stall = i_full;

    always_comb begin
        hex_ok  = 1'b0;
        hex_val = i_in_byte[3:0];
        if (i_in_byte >= CH_0 && i_in_byte <= CH_9) begin
            hex_ok = 1'b1;
        end else if ((i_in_byte >= CH_LC_A && i_in_byte <= CH_LC_F) ||
                     (i_in_byte >= CH_UC_A && i_in_byte <= CH_UC_F)) begin
            hex_ok  = 1'b1;
            hex_val = i_in_byte[3:0] + 4'd9;
        end
        oct_ok = (i_in_byte >= CH_0) && (i_in_byte <= CH_7);
    end

    always_comb begin
        n_phase  = PH_PLAIN;
        n_accum  = r_accum;
        do_plain = 1'b0;
        ent      = '{cnt: 2'd0, b0: 8'h00, b1: 8'h00, last: i_template_end};

        unique case (r_phase)
            PH_ESC: begin
                unique case (i_in_byte)
                    CH_LC_A: ent = add_byte(ent, 8'd7);
                    CH_LC_B: ent = add_byte(ent, 8'd8);
                    CH_LC_F: ent = add_byte(ent, 8'd12);
                    CH_LC_N: ent = add_byte(ent, 8'd10);
                    CH_LC_R: ent = add_byte(ent, 8'd13);
                    CH_LC_T: ent = add_byte(ent, 8'd9);
                    CH_LC_V: ent = add_byte(ent, 8'd11);
                    CH_LC_X: n_phase = PH_HEX0;
                    CH_NL: begin
                    end
                    CH_FF: begin
                        ent = add_byte(ent, 8'h00);
                        ent = add_byte(ent, CH_FF);
                    end
                    default: begin
                        if (oct_ok) begin
                            n_accum = {3'd0, i_in_byte[2:0]};
                            n_phase = PH_OCT1;
                        end else begin
                            ent = add_byte(ent, i_in_byte);
                        end
                    end
                endcase
            end
            PH_HEX0: begin
                if (hex_ok) begin
                    n_accum = {2'd0, hex_val};
                    n_phase = PH_HEX1;
                end else begin
                    ent      = add_byte(ent, CH_LC_X);
                    do_plain = 1'b1;
                end
            end
            PH_HEX1: begin
                if (hex_ok) begin
                    ent = add_byte(ent, {r_accum[3:0], hex_val});
                end else begin
                    ent      = add_byte(ent, {2'd0, r_accum});
                    do_plain = 1'b1;
                end
            end
            PH_OCT1: begin
                if (oct_ok) begin
                    n_accum = {r_accum[2:0], i_in_byte[2:0]};
                    n_phase = PH_OCT2;
                end else begin
                    ent      = add_byte(ent, {2'd0, r_accum});
                    do_plain = 1'b1;
                end
            end
            PH_OCT2: begin
                if (oct_ok) begin
                    ent = add_byte(ent, {r_accum[4:0], i_in_byte[2:0]});
                end else begin
                    ent      = add_byte(ent, {2'd0, r_accum});
                    do_plain = 1'b1;
                end
            end
            default: do_plain = 1'b1;
        endcase

        if (do_plain) begin
            if (i_in_byte == CH_BSLASH) begin
                n_phase = PH_ESC;
            end else begin
                ent     = add_byte(ent, i_in_byte);
                n_phase = PH_PLAIN;
            end
        end

        if (i_template_end) begin
            priority case (n_phase)
                PH_HEX0: ent = add_byte(ent, CH_LC_X);
                PH_HEX1, PH_OCT1, PH_OCT2: ent = add_byte(ent, {2'd0, n_accum});
                default: begin
                end
            endcase
            n_phase = PH_PLAIN;
            n_accum = 6'd0;
        end
    end

    assign o_push  = accept && ((ent.cnt != 2'd0) || ent.last);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_accum <= 6'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_template_end) |=> (r_phase == PH_PLAIN && r_accum == 6'd0))
        else $error("escape state not cleared after template end");

endmodule

// ===== hw/rtl/bdec_fifo.sv =====
// ----------------------------------------------------------------------------
// bdec_fifo
// Short entry queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module bdec_fifo import bdec_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue push while full or pop while empty");

endmodule

// ===== hw/rtl/bdec_back.sv =====
// ----------------------------------------------------------------------------
// bdec_back
// Output sequencer: walks queue entries one byte per cycle when not stalled,
// applies the length limit and overflow drop, and frames template ends.
// ----------------------------------------------------------------------------
module bdec_back import bdec_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_entry               i_head,
    input  logic                 i_head_valid,
    output logic                 o_pop,
    input  logic [MAX_LEN_W-1:0] i_max_length,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_valid,
    output logic                 o_out_last,
    output logic                 o_overflow
);

    logic                 r_sel, n_sel;
    logic [MAX_LEN_W-1:0] r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic                 r_oval, n_oval;
    logic [7:0]           r_obyte, n_obyte;
    logic                 r_ofval, n_ofval;
    logic                 r_olast, n_olast;
    logic                 r_oovf, n_oovf;

    logic                 adv;
    logic                 hit;
    logic                 last_slot;
    logic [7:0]           cur;

    assign adv       = !r_oval || !i_stall;
    assign hit       = (r_count >= i_max_length);
    assign last_slot = r_sel || (i_head.cnt == 2'd1);
    assign cur       = r_sel ? i_head.b1 : i_head.b0;

    always_comb begin
        n_sel   = r_sel;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_oval  = r_oval && i_stall;
        n_obyte = r_obyte;
        n_ofval = r_ofval;
        n_olast = r_olast;
        n_oovf  = r_oovf;
        o_pop   = 1'b0;

        if (adv && i_head_valid) begin
            if (r_ovf || (i_head.cnt == 2'd0)) begin
                // bare end marker, or everything left is dropped
                n_oval  = i_head.last;
                n_obyte = 8'h00;
                n_ofval = 1'b0;
                n_olast = 1'b1;
                n_oovf  = r_ovf;
                o_pop   = 1'b1;
            end else begin
                n_oval  = 1'b1;
                n_obyte = cur;
                n_ofval = 1'b1;
                n_olast = i_head.last && (last_slot || hit);
                n_oovf  = hit;
                if (hit) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + MAX_LEN_W'(1);
                end
                o_pop = last_slot || hit;
                n_sel = !(last_slot || hit);
            end
            if (o_pop && i_head.last) begin
                n_sel   = 1'b0;
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_sel   <= n_sel;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_oval  <= n_oval;
        end
        r_obyte <= n_obyte;
        r_ofval <= n_ofval;
        r_olast <= n_olast;
        r_oovf  <= n_oovf;
    end

    assign o_valid     = r_oval;
    assign o_out_byte  = r_obyte;
    assign o_out_valid = r_ofval;
    assign o_out_last  = r_olast;
    assign o_overflow  = r_oovf;

    a_second_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (i_head_valid && i_head.cnt == 2'd2 && !r_ovf))
        else $error("second slot selected without a two-byte entry");

    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !r_ofval) |-> (r_olast && r_obyte == 8'h00))
        else $error("end marker without last flag or with nonzero byte");

endmodule

// ===== hw/rtl/backslash_escape_decoder_top.sv =====
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top
// C-style backslash escape decoder with output length limit.
// ----------------------------------------------------------------------------
// Takes one template byte per cycle. Each byte yields zero, one or two
// decoded results; the result side delivers one result per cycle unless
// stalled, so a byte that yields two results (escaped 0xFF, or a flushed
// number followed by a plain byte) keeps it busy with both, absorbed by a
// four-entry queue between the parser and the output sequencer. Input stall
// rises only when that queue is full. max_length resets to 2000 and is
// written through the config port, which is always ready.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_top import bdec_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_template_end,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_valid,
    output logic                 o_out_last,
    output logic                 o_overflow,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MAX_LEN_W-1:0] i_cfg_data
);

    logic                 cfg_write;
    logic [MAX_LEN_W-1:0] r_max;
    logic                 q_full, q_valid, q_push, q_pop;
    t_entry               q_in, q_head;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_LEN_RESET;
        end else if (cfg_write) begin
            r_max <= i_cfg_data;
        end
    end

    bdec_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_template_end (i_template_end),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_entry        (q_in)
    );

    bdec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    bdec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (q_valid),
        .o_pop        (q_pop),
        .i_max_length (r_max),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_out_valid  (o_out_valid),
        .o_out_last   (o_out_last),
        .o_overflow   (o_overflow)
    );

endmodule

// ===== tb/backslash_escape_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// backslash_escape_decoder_checker
// Predicts and checks the decoded byte stream of the escape decoder.
// ----------------------------------------------------------------------------
// Watches the template, result and max_length channels at each rising edge.
// Every template byte transfer runs through a local escape decoder that
// keeps its own phase, number accumulator, output count and overflow flag.
// The decoded bytes it produces are queued. Each result transfer is
// compared field by field against the oldest queued byte. The number of
// bytes still owed and the error count are passed up to the testbench top.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_checker import bdec_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_src_valid,
    input  logic                 i_src_stall,
    input  logic [7:0]           i_src_byte,
    input  logic                 i_src_end,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [7:0]           i_res_byte,
    input  logic                 i_res_byte_valid,
    input  logic                 i_res_last,
    input  logic                 i_res_overflow,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [MAX_LEN_W-1:0] i_cfg_data,
    output int                   o_pending,
    output int                   o_error_count
);

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_HT        = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ALL_ONES  = 8'hFF;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_ESCAPE,
        PH_HEX_FIRST,
        PH_HEX_SECOND,
        PH_OCT_SECOND,
        PH_OCT_THIRD
    } t_esc_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       last;
        logic       ovf;
    } t_dec_result;

    t_esc_phase           phase;
    logic [8:0]           accum;
    logic [MAX_LEN_W-1:0] out_count;
    logic                 ovf_seen;
    logic [MAX_LEN_W-1:0] max_len;

    t_dec_result          step_res [2];
    int                   step_n;
    t_dec_result          decoded_q [$];
    int                   result_idx;

    initial begin
        o_pending     = 0;
        o_error_count = 0;
        result_idx    = 0;
    end

    task automatic report_error(input string msg);
        $display("ERROR: %s", msg);
        o_error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_error($sformatf("result %0d: %s is %0h, expected %0h",
                                   result_idx, name, got, want));
        end
    endtask

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        if (!ovf_seen && step_n < 2) begin
            if (out_count >= max_len) ovf_seen = 1'b1;
            else out_count = out_count + 1'b1;
            step_res[step_n] = {b, 1'b1, 1'b0, ovf_seen};
            step_n++;
        end
    endtask

    task automatic text_byte(input logic [7:0] b);
        phase = PH_TEXT;
        if (b == CH_BACKSLASH) phase = PH_ESCAPE;
        else emit_byte(b);
    endtask

    task automatic escaped_byte(input logic [7:0] b);
        phase = PH_TEXT;
        case (b)
            "a": emit_byte(CH_BEL);
            "b": emit_byte(CH_BS);
            "f": emit_byte(CH_FF);
            "n": emit_byte(CH_LF);
            "r": emit_byte(CH_CR);
            "t": emit_byte(CH_HT);
            "v": emit_byte(CH_VT);
            CH_X: phase = PH_HEX_FIRST;
            CH_LF: ;
            CH_ALL_ONES: begin
                emit_byte(CH_NUL);
                emit_byte(CH_ALL_ONES);
            end
            default: begin
                if (b >= "0" && b <= "7") begin
                    accum = {6'd0, b[2:0]};
                    phase = PH_OCT_SECOND;
                end else begin
                    emit_byte(b);
                end
            end
        endcase
    endtask

    task automatic decode_step(input logic [7:0] b, input logic tmpl_end);
        int   hv;
        logic is_oct;
        hv     = hex_digit(b);
        is_oct = (b >= "0") && (b <= "7");
        step_n = 0;
        case (phase)
            PH_ESCAPE: escaped_byte(b);
            PH_HEX_FIRST: begin
                if (hv >= 0) begin
                    accum = hv[8:0];
                    phase = PH_HEX_SECOND;
                end else begin
                    emit_byte(CH_X);
                    text_byte(b);
                end
            end
            PH_HEX_SECOND: begin
                if (hv >= 0) begin
                    emit_byte({accum[3:0], hv[3:0]});
                    phase = PH_TEXT;
                end else begin
                    emit_byte(accum[7:0]);
                    text_byte(b);
                end
            end
            PH_OCT_SECOND: begin
                if (is_oct) begin
                    accum = {accum[5:0], b[2:0]};
                    phase = PH_OCT_THIRD;
                end else begin
                    emit_byte(accum[7:0]);
                    text_byte(b);
                end
            end
            PH_OCT_THIRD: begin
                if (is_oct) begin
                    emit_byte({accum[4:0], b[2:0]});
                    phase = PH_TEXT;
                end else begin
                    emit_byte(accum[7:0]);
                    text_byte(b);
                end
            end
            default: text_byte(b);
        endcase

        if (tmpl_end) begin
            // flush a pending number; bare \x flushes as 'x'
            case (phase)
                PH_HEX_FIRST: emit_byte(CH_X);
                PH_HEX_SECOND, PH_OCT_SECOND, PH_OCT_THIRD: emit_byte(accum[7:0]);
                default: ;
            endcase
            if (step_n == 0) begin
                step_res[0] = {CH_NUL, 1'b0, 1'b1, ovf_seen};
                step_n = 1;
            end else begin
                step_res[step_n-1].last = 1'b1;
            end
            phase     = PH_TEXT;
            accum     = '0;
            out_count = '0;
            ovf_seen  = 1'b0;
        end

        for (int k = 0; k < step_n; k++) decoded_q.push_back(step_res[k]);
    endtask

    always @(posedge i_clk) begin
        t_dec_result want;
        if (!i_rst_n) begin
            phase     = PH_TEXT;
            accum     = '0;
            out_count = '0;
            ovf_seen  = 1'b0;
            max_len   = MAX_LEN_RESET;
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) max_len = i_cfg_data;
            if (i_res_valid && !i_res_stall) begin
                if (decoded_q.size() == 0) begin
                    report_error($sformatf(
                        "unexpected result: byte %02h valid %0b last %0b overflow %0b",
                        i_res_byte, i_res_byte_valid, i_res_last, i_res_overflow));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", i_res_byte, want.data);
                    check_field("out_valid", i_res_byte_valid, want.data_valid);
                    check_field("out_last", i_res_last, want.last);
                    check_field("overflow", i_res_overflow, want.ovf);
                end
                result_idx++;
            end
            if (i_src_valid && !i_src_stall) decode_step(i_src_byte, i_src_end);
        end
        o_pending <= decoded_q.size();
    end

endmodule

// ===== tb/backslash_escape_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top_tb
// Stimulus and verdict for the backslash escape decoder.
// ----------------------------------------------------------------------------
// A few directed templates hit the corner escapes and the overflow limit,
// then phases of random templates run under different max_length values.
// Templates are mostly well-formed escape sequences with random content,
// mixed with raw noise bytes and broken escapes. Both channels idle at
// random; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_top_tb;
    import bdec_pkg::*;

    localparam int ITEM_GOAL    = 650;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic [7:0]           i_in_byte      = 8'h00;
    logic                 i_template_end = 1'b0;
    logic                 i_stall        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [MAX_LEN_W-1:0] i_cfg_data     = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [7:0]           o_out_byte;
    logic                 o_out_valid;
    logic                 o_out_last;
    logic                 o_overflow;
    logic                 o_cfg_ready;

    int                   pending;
    int                   error_count;
    int                   items_sent;
    int                   cycle_count;
    int                   seg_left;
    logic                 in_quiet  = 1'b0;
    logic                 out_quiet = 1'b0;
    logic [7:0]           tmpl_q [$];

    always #2 i_clk = ~i_clk;

    backslash_escape_decoder_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_template_end (i_template_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_out_valid    (o_out_valid),
        .o_out_last     (o_out_last),
        .o_overflow     (o_overflow),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    backslash_escape_decoder_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_src_valid      (i_valid),
        .i_src_stall      (o_stall),
        .i_src_byte       (i_in_byte),
        .i_src_end        (i_template_end),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_res_byte       (o_out_byte),
        .i_res_byte_valid (o_out_valid),
        .i_res_last       (o_out_last),
        .i_res_overflow   (o_overflow),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_pending        (pending),
        .o_error_count    (error_count)
    );

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // result-side stall: alternating random stall/run segments
    always @(posedge i_clk) begin
        if (!i_rst_n || out_quiet) begin
            i_stall  <= 1'b0;
            seg_left <= 0;
        end else if (seg_left > 0) begin
            seg_left <= seg_left - 1;
        end else begin
            i_stall  <= ($urandom_range(0, 2) == 0);
            seg_left <= pick_gap();
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic tmpl_end);
        int gap;
        i_valid        <= 1'b1;
        i_in_byte      <= b;
        i_template_end <= tmpl_end;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        gap = (in_quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [MAX_LEN_W-1:0] v);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++) tmpl_q.push_back(s[k]);
    endtask

    task automatic send_tmpl();
        for (int k = 0; k < tmpl_q.size(); k++) begin
            send_item(tmpl_q[k], k == tmpl_q.size() - 1);
            if ($urandom_range(0, 59) == 0) wait_drained();
        end
        tmpl_q.delete();
    endtask

    task automatic add_token();
        int         r;
        int         cnt;
        logic [7:0] b;
        string      esc_letters;
        string      hex_chars;
        esc_letters = "abfnrtv\\'\"?";
        hex_chars   = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 99);
        if (r < 35) begin
            b = 8'($urandom_range(32, 126));
            if (b == 8'h5C) b = "a";
            tmpl_q.push_back(b);
        end else if (r < 45) begin
            tmpl_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 60) begin
            add_str("\\");
            tmpl_q.push_back(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
        end else if (r < 72) begin
            add_str("\\x");
            cnt = $urandom_range(0, 2);
            repeat (cnt) tmpl_q.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
        end else if (r < 84) begin
            add_str("\\");
            cnt = $urandom_range(1, 3);
            repeat (cnt) tmpl_q.push_back(8'(8'h30 + $urandom_range(0, 7)));
        end else if (r < 89) begin
            add_str("\\\n");
        end else if (r < 93) begin
            add_str("\\");
            tmpl_q.push_back(8'hFF);
        end else if (r < 97) begin
            add_str("\\");
            tmpl_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_str("\\");
        end
    endtask

    task automatic build_random_template();
        int tlen;
        tmpl_q.delete();
        tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        while (tmpl_q.size() < tlen) add_token();
    endtask

    initial begin
        int                   phase_idx;
        logic                 quiet;
        logic [MAX_LEN_W-1:0] len_v;
        items_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset max_length
        add_str("\\x");
        send_tmpl();
        wait_drained();
        add_str("\\");
        send_tmpl();
        tmpl_q.push_back(8'h00);
        add_str("%");
        tmpl_q.push_back(8'hFF);
        add_str("\\");
        tmpl_q.push_back(8'hFF);
        add_str("\\\n\\xg\\123\\777\\x4");
        send_tmpl();

        // limit of zero: first byte flagged, rest dropped
        write_max_length('0);
        add_str("ab");
        send_tmpl();

        phase_idx = 0;
        while (items_sent < ITEM_GOAL) begin
            case (phase_idx % 6)
                0: len_v = '1;
                1: len_v = MAX_LEN_W'($urandom_range(1, 8));
                2: len_v = '0;
                3: len_v = MAX_LEN_RESET;
                4: len_v = MAX_LEN_W'($urandom_range(9, 40));
                default: len_v = MAX_LEN_W'($urandom_range(0, 4095));
            endcase
            write_max_length(len_v);
            quiet = (phase_idx % 4 == 2);
            in_quiet = quiet;
            out_quiet <= quiet;
            repeat (10) begin
                build_random_template();
                send_tmpl();
            end
            phase_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
